>>> design/scp_pkg.sv
// ============================================================================
// scp_pkg
// Widths, record types and arithmetic helpers for the segment closest-points
// pipeline.
// ============================================================================
`default_nettype none

package scp_pkg;

  // Coordinate and fraction widths
  localparam int CW        = 32;            // coordinate width
  localparam int FB        = 16;            // fraction bits
  localparam int DW        = CW + 1;        // coordinate difference width
  localparam int PW        = 2 * DW;        // difference product width
  localparam int DOTW      = PW + 2;        // dot product width
  localparam int HW        = DOTW / 2;      // half of a dot product for splitting
  localparam int NW        = 2 * DOTW + 4;  // determinant and numerator width
  localparam int QW        = FB + 1;        // s and t width
  localparam int THR_SHIFT = 3 * FB;        // threshold alignment to 4*FB fraction bits
  localparam int PTW       = CW + 3;        // closest point width before truncation
  localparam int DKW       = PTW + 1;       // point difference width
  localparam int SQW       = 2 * DKW;       // squared difference width
  localparam int SUMW      = SQW + 2;       // sum of squares width
  localparam int DISTW     = CW + 1;        // distance width
  localparam int RADW      = 2 * DISTW;     // radicand width below saturation
  localparam int REMW      = RADW + 2;      // square root remainder width
  localparam int DIV_STEPS = FB;            // quotient bits per ratio
  localparam int SQ_STEPS  = DISTW;         // root bits
  localparam int IN_W      = 12 * CW;       // input beat width
  localparam int OUT_RAW   = 6 * CW + 2 * QW + DISTW;
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8;

  localparam logic [QW-1:0] ONE_Q = QW'(1) << FB;

  // Four partial products of a split wide multiply
  typedef struct packed {
    logic signed [2*HW-1:0] hh;
    logic signed [2*HW:0]   hl;
    logic signed [2*HW:0]   lh;
    logic        [2*HW-1:0] ll;
  } part_t;

  // Segment geometry carried down the pipe
  typedef struct packed {
    logic [2:0][CW-1:0] p0;
    logic [2:0][CW-1:0] q0;
    logic [2:0][DW-1:0] p;
    logic [2:0][DW-1:0] q;
  } geo_t;

  // One restoring-division lane
  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] den;
    logic [FB-1:0] quo;
    logic          zero;
    logic          one;
  } div_t;

  // Result fields waiting for the distance
  typedef struct packed {
    logic [2:0][CW-1:0] ps;
    logic [2:0][CW-1:0] qt;
    logic [QW-1:0]      s;
    logic [QW-1:0]      t;
  } res_t;

  // One square root lane
  typedef struct packed {
    logic [REMW-1:0]  rem;
    logic [DISTW-1:0] root;
    logic             sat;
  } sq_t;

  // Split a signed dot-product multiply into four narrow products
  function automatic part_t pmul(input logic signed [DOTW-1:0] x,
                                 input logic signed [DOTW-1:0] y);
    logic signed [HW-1:0] xh;
    logic signed [HW-1:0] yh;
    logic signed [HW:0]   xl;
    logic signed [HW:0]   yl;
    part_t                r;
    xh   = x[DOTW-1:HW];
    yh   = y[DOTW-1:HW];
    xl   = {1'b0, x[HW-1:0]};
    yl   = {1'b0, y[HW-1:0]};
    r.hh = xh * yh;
    r.hl = xh * yl;
    r.lh = xl * yh;
    r.ll = x[HW-1:0] * y[HW-1:0];
    return r;
  endfunction

  // Recombine the partial products into the full signed product
  function automatic logic signed [NW-1:0] pjoin(input part_t m);
    logic signed [NW-1:0] r;
    r = (NW'(m.hh) <<< (2 * HW)) + (NW'(m.hl) <<< HW) + (NW'(m.lh) <<< HW) + NW'(m.ll);
    return r;
  endfunction

  // One quotient bit of a restoring division
  function automatic div_t div_step(input div_t x);
    logic [NW-1:0] sh;
    logic          ge;
    div_t          r;
    sh    = {x.rem[NW-2:0], 1'b0};
    ge    = (sh >= x.den);
    r     = x;
    r.rem = ge ? (sh - x.den) : sh;
    r.quo = {x.quo[FB-2:0], ge};
    return r;
  endfunction

  // One root bit of a digit-by-digit square root
  function automatic sq_t sqrt_step(input sq_t x, input int b);
    logic [REMW-1:0] trial;
    sq_t             r;
    trial = (REMW'(x.root) << (b + 1)) | (REMW'(1) << (2 * b));
    r     = x;
    if (x.rem >= trial) begin
      r.rem     = x.rem - trial;
      r.root[b] = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/segment_closest_points_top.sv
// ============================================================================
// segment_closest_points_top
// Closest points, parameters and distance between two 3D segments, streamed.
// ============================================================================
// Usage:
//   Slave side s_tvalid/s_tready/s_tdata carries one segment pair per beat:
//   twelve signed Q16.16 coordinates. Master side m_tvalid/m_tready/m_tdata
//   returns one result beat per pair: both closest points, s, t and the
//   saturated distance. cfg_we/cfg_wdata writes parallel_threshold (reset 1).
//   Throughput: one pair per cycle while the output is not stalled. From
//   acceptance to m_tvalid a pair passes 8 arithmetic stages, 16 divider stages
//   (one quotient bit each, s and t side by side), 4 point/sum stages and 33
//   square-root stages (one root bit each).
//   Every stage advances together; when m_tvalid is high and m_tready low
//   the whole pipe holds and s_tready drops in the same cycle, so nothing is
//   lost or repeated. Reset clears all valid bits and restores the threshold;
//   payload registers are not reset.
// ============================================================================
`default_nettype none

module segment_closest_points_top
  import scp_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [CW-1:0]     cfg_wdata,
  input  wire              s_tvalid,
  output logic             s_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, q0_x, q0_y, q0_z, q1_x, q1_y, q1_z
  input  wire [IN_W-1:0]   s_tdata,
  output logic             m_tvalid,
  input  wire              m_tready,
  // ps_x, ps_y, ps_z, qt_x, qt_y, qt_z, param_s, param_t, distance, zero pad
  output logic [OUT_W-1:0] m_tdata
);

  logic [CW-1:0] parallel_threshold;
  logic          en;

  // Stage registers
  logic                    s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v;
  geo_t                    s1_geo, s2_geo, s3_geo, s4_geo, s5_geo, s6_geo, s7_geo;
  logic signed [DW-1:0]    s1_p [3];
  logic signed [DW-1:0]    s1_q [3];
  logic signed [DW-1:0]    s1_r [3];
  logic signed [PW-1:0]    s2_pp [3];
  logic signed [PW-1:0]    s2_pq [3];
  logic signed [PW-1:0]    s2_qq [3];
  logic signed [PW-1:0]    s2_pr [3];
  logic signed [PW-1:0]    s2_qr [3];
  logic signed [DOTW-1:0]  s3_a, s3_b, s3_c, s3_d, s3_e;
  logic signed [DOTW-1:0]  s4_a, s4_b, s4_c, s4_d, s4_e;
  part_t                   s4_ac, s4_bb, s4_be, s4_cd, s4_ae, s4_bd;
  logic signed [DOTW-1:0]  s5_a, s5_b, s5_c, s5_d, s5_e;
  logic signed [NW-1:0]    s5_ac, s5_bb, s5_bte, s5_ctd, s5_ate, s5_btd;
  logic signed [NW-1:0]    s6_det, s6_sn, s6_tn, s6_be, s6_nd, s6_bmd, s6_a, s6_c, s6_e;
  logic signed [NW-1:0]    s7_sn, s7_sd, s7_tn, s7_td;

  // Divider and square root pipes
  logic dvv [DIV_STEPS+1];
  div_t ds  [DIV_STEPS+1];
  div_t dt  [DIV_STEPS+1];
  geo_t dg  [DIV_STEPS+1];

  logic                      r1_v, r2_v, r3_v;
  geo_t                      r1_geo;
  logic [QW-1:0]             r1_s, r1_t, r2_s, r2_t, r3_s, r3_t;
  logic signed [QW+DW-1:0]   r1_sp [3];
  logic signed [QW+DW-1:0]   r1_tq [3];
  logic [2:0][CW-1:0]        r2_ps, r2_qt, r3_ps, r3_qt;
  logic signed [DKW-1:0]     r2_dk [3];
  logic signed [SQW-1:0]     r3_sq [3];

  logic sv [SQ_STEPS+1];
  sq_t  sq [SQ_STEPS+1];
  res_t rr [SQ_STEPS+1];

  // Combinational helpers
  logic signed [DW-1:0]  c_p [3];
  logic signed [DW-1:0]  c_q [3];
  logic signed [DW-1:0]  c_r [3];
  geo_t                  c_geo;
  logic signed [NW-1:0]  c_thr;
  logic signed [NW-1:0]  c_sn, c_sd, c_tn, c_td;
  logic [QW-1:0]         c_s, c_t;
  logic signed [PTW-1:0] c_ps [3];
  logic signed [PTW-1:0] c_qt [3];
  logic [SUMW-1:0]       c_sum;

  // Whole pipe advances unless the output beat is stalled
  assign en       = !sv[SQ_STEPS] || m_tready;
  assign s_tready = en;
  assign m_tvalid = sv[SQ_STEPS];
  assign m_tdata  = {(OUT_W - OUT_RAW)'(0),
                     (sq[SQ_STEPS].sat ? {DISTW{1'b1}} : sq[SQ_STEPS].root),
                     rr[SQ_STEPS].t, rr[SQ_STEPS].s, rr[SQ_STEPS].qt, rr[SQ_STEPS].ps};

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_threshold <= CW'(1);
    end else if (cfg_we) begin
      parallel_threshold <= cfg_wdata;
    end
  end

  // Valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0;
      s5_v <= 1'b0; s6_v <= 1'b0; s7_v <= 1'b0;
      r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
    end else if (en) begin
      s1_v <= s_tvalid; s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v;
      s5_v <= s4_v; s6_v <= s5_v; s7_v <= s6_v;
      r1_v <= dvv[DIV_STEPS]; r2_v <= r1_v; r3_v <= r2_v;
    end
  end

  // Unpack the beat and form edge and offset vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_geo.p0[k] = s_tdata[k*CW +: CW];
      c_geo.q0[k] = s_tdata[(6+k)*CW +: CW];
      c_p[k] = DW'($signed(s_tdata[(3+k)*CW +: CW])) - DW'($signed(s_tdata[k*CW +: CW]));
      c_q[k] = DW'($signed(s_tdata[(9+k)*CW +: CW])) - DW'($signed(s_tdata[(6+k)*CW +: CW]));
      c_r[k] = DW'($signed(s_tdata[k*CW +: CW])) - DW'($signed(s_tdata[(6+k)*CW +: CW]));
      c_geo.p[k] = c_p[k];
      c_geo.q[k] = c_q[k];
    end
  end

  // Stages 1 to 7: vectors, products, dots, split products, joins, differences, region picks
  always_ff @(posedge clk) begin
    if (en) begin
      s1_geo <= c_geo;
      for (int k = 0; k < 3; k++) begin
        s1_p[k]  <= c_p[k];
        s1_q[k]  <= c_q[k];
        s1_r[k]  <= c_r[k];
        s2_pp[k] <= s1_p[k] * s1_p[k];
        s2_pq[k] <= s1_p[k] * s1_q[k];
        s2_qq[k] <= s1_q[k] * s1_q[k];
        s2_pr[k] <= s1_p[k] * s1_r[k];
        s2_qr[k] <= s1_q[k] * s1_r[k];
      end
      s2_geo <= s1_geo;
      s3_geo <= s2_geo;
      s3_a <= DOTW'(s2_pp[0]) + DOTW'(s2_pp[1]) + DOTW'(s2_pp[2]);
      s3_b <= DOTW'(s2_pq[0]) + DOTW'(s2_pq[1]) + DOTW'(s2_pq[2]);
      s3_c <= DOTW'(s2_qq[0]) + DOTW'(s2_qq[1]) + DOTW'(s2_qq[2]);
      s3_d <= DOTW'(s2_pr[0]) + DOTW'(s2_pr[1]) + DOTW'(s2_pr[2]);
      s3_e <= DOTW'(s2_qr[0]) + DOTW'(s2_qr[1]) + DOTW'(s2_qr[2]);
      s4_geo <= s3_geo;
      s4_a <= s3_a; s4_b <= s3_b; s4_c <= s3_c; s4_d <= s3_d; s4_e <= s3_e;
      s4_ac <= pmul(s3_a, s3_c);
      s4_bb <= pmul(s3_b, s3_b);
      s4_be <= pmul(s3_b, s3_e);
      s4_cd <= pmul(s3_c, s3_d);
      s4_ae <= pmul(s3_a, s3_e);
      s4_bd <= pmul(s3_b, s3_d);
      s5_geo <= s4_geo;
      s5_a <= s4_a; s5_b <= s4_b; s5_c <= s4_c; s5_d <= s4_d; s5_e <= s4_e;
      s5_ac  <= pjoin(s4_ac);
      s5_bb  <= pjoin(s4_bb);
      s5_bte <= pjoin(s4_be);
      s5_ctd <= pjoin(s4_cd);
      s5_ate <= pjoin(s4_ae);
      s5_btd <= pjoin(s4_bd);
      s6_geo <= s5_geo;
      s6_det <= s5_ac - s5_bb;
      s6_sn  <= s5_bte - s5_ctd;
      s6_tn  <= s5_ate - s5_btd;
      s6_be  <= NW'(s5_b) + NW'(s5_e);
      s6_nd  <= -NW'(s5_d);
      s6_bmd <= NW'(s5_b) - NW'(s5_d);
      s6_a   <= NW'(s5_a);
      s6_c   <= NW'(s5_c);
      s6_e   <= NW'(s5_e);
      s7_geo <= s6_geo;
      s7_sn  <= c_sn; s7_sd <= c_sd;
      s7_tn  <= c_tn; s7_td <= c_td;
    end
  end

  // Region split: pick numerator and denominator of s and t
  always_comb begin
    c_thr = {{(NW - CW - THR_SHIFT){1'b0}}, parallel_threshold, {THR_SHIFT{1'b0}}};
    c_sn = s6_nd;  c_sd = s6_a;
    c_tn = '0;     c_td = NW'(1);
    if (s6_det > c_thr) begin
      if (s6_sn <= 0) begin
        if (s6_e <= 0) begin
          c_sn = s6_nd;  c_sd = s6_a;  c_tn = '0;      c_td = NW'(1);
        end else if (s6_e < s6_c) begin
          c_sn = '0;     c_sd = NW'(1); c_tn = s6_e;   c_td = s6_c;
        end else begin
          c_sn = s6_bmd; c_sd = s6_a;  c_tn = NW'(1);  c_td = NW'(1);
        end
      end else if (s6_sn >= s6_det) begin
        if (s6_be <= 0) begin
          c_sn = s6_nd;  c_sd = s6_a;  c_tn = '0;      c_td = NW'(1);
        end else if (s6_be < s6_c) begin
          c_sn = NW'(1); c_sd = NW'(1); c_tn = s6_be;  c_td = s6_c;
        end else begin
          c_sn = s6_bmd; c_sd = s6_a;  c_tn = NW'(1);  c_td = NW'(1);
        end
      end else if (s6_tn <= 0) begin
        c_sn = s6_nd;  c_sd = s6_a;   c_tn = '0;      c_td = NW'(1);
      end else if (s6_tn >= s6_det) begin
        c_sn = s6_bmd; c_sd = s6_a;   c_tn = NW'(1);  c_td = NW'(1);
      end else begin
        c_sn = s6_sn;  c_sd = s6_det; c_tn = s6_tn;   c_td = s6_det;
      end
    end else begin
      if (s6_e <= 0) begin
        c_sn = s6_nd;  c_sd = s6_a;   c_tn = '0;      c_td = NW'(1);
      end else if (s6_e >= s6_c) begin
        c_sn = s6_bmd; c_sd = s6_a;   c_tn = NW'(1);  c_td = NW'(1);
      end else begin
        c_sn = '0;     c_sd = NW'(1); c_tn = s6_e;    c_td = s6_c;
      end
    end
  end

  // Stage 8: load the divider lanes, flag the clamped cases
  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (en) begin
      dvv[0] <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg[0]      <= s7_geo;
      ds[0].zero <= (s7_sn <= 0);
      ds[0].one  <= (s7_sn >= s7_sd);
      ds[0].rem  <= ((s7_sn <= 0) || (s7_sn >= s7_sd)) ? '0 : s7_sn;
      ds[0].den  <= s7_sd;
      ds[0].quo  <= '0;
      dt[0].zero <= (s7_tn <= 0);
      dt[0].one  <= (s7_tn >= s7_td);
      dt[0].rem  <= ((s7_tn <= 0) || (s7_tn >= s7_td)) ? '0 : s7_tn;
      dt[0].den  <= s7_td;
      dt[0].quo  <= '0;
    end
  end

  // Divider stages: one quotient bit of s and t per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[i+1] <= 1'b0;
      end else if (en) begin
        dvv[i+1] <= dvv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dg[i+1] <= dg[i];
        ds[i+1] <= div_step(ds[i]);
        dt[i+1] <= div_step(dt[i]);
      end
    end
  end

  // Clamp the quotients, form the closest points and sum the squared differences
  always_comb begin
    c_s = ds[DIV_STEPS].zero ? '0 :
          ds[DIV_STEPS].one  ? ONE_Q : {1'b0, ds[DIV_STEPS].quo};
    c_t = dt[DIV_STEPS].zero ? '0 :
          dt[DIV_STEPS].one  ? ONE_Q : {1'b0, dt[DIV_STEPS].quo};
    for (int k = 0; k < 3; k++) begin
      c_ps[k] = PTW'($signed(r1_geo.p0[k])) + PTW'(r1_sp[k] >>> FB);
      c_qt[k] = PTW'($signed(r1_geo.q0[k])) + PTW'(r1_tq[k] >>> FB);
    end
    c_sum = SUMW'(r3_sq[0]) + SUMW'(r3_sq[1]) + SUMW'(r3_sq[2]);
  end

  // Point stages: scale edges, add starts, square differences
  always_ff @(posedge clk) begin
    if (en) begin
      r1_geo <= dg[DIV_STEPS];
      r1_s   <= c_s;
      r1_t   <= c_t;
      for (int k = 0; k < 3; k++) begin
        r1_sp[k] <= $signed({1'b0, c_s}) * $signed(dg[DIV_STEPS].p[k]);
        r1_tq[k] <= $signed({1'b0, c_t}) * $signed(dg[DIV_STEPS].q[k]);
        r2_ps[k] <= c_ps[k][CW-1:0];
        r2_qt[k] <= c_qt[k][CW-1:0];
        r2_dk[k] <= DKW'(c_qt[k]) - DKW'(c_ps[k]);
        r3_sq[k] <= r2_dk[k] * r2_dk[k];
      end
      r2_s  <= r1_s;  r2_t  <= r1_t;
      r3_s  <= r2_s;  r3_t  <= r2_t;
      r3_ps <= r2_ps; r3_qt <= r2_qt;
    end
  end

  // Load the square root lane, saturate large sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= r3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].sat  <= |c_sum[SUMW-1:RADW];
      sq[0].rem  <= (|c_sum[SUMW-1:RADW]) ? '0 : REMW'(c_sum[RADW-1:0]);
      sq[0].root <= '0;
      rr[0].ps   <= r3_ps;
      rr[0].qt   <= r3_qt;
      rr[0].s    <= r3_s;
      rr[0].t    <= r3_t;
    end
  end

  // Square root stages: one root bit per stage, top bit first
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[j+1] <= rr[j];
        sq[j+1] <= sqrt_step(sq[j], SQ_STEPS - 1 - j);
      end
    end
  end

`ifndef ASSERT_OFF
  // Parameters leave the pipe clamped to the unit interval
  a_param_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (rr[SQ_STEPS].s <= ONE_Q) && (rr[SQ_STEPS].t <= ONE_Q))
    else $error("param_s or param_t above one");

  // Divider remainder of an unclamped ratio stays below its denominator
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dvv[DIV_STEPS] && !ds[DIV_STEPS].zero && !ds[DIV_STEPS].one
    |-> ds[DIV_STEPS].rem < ds[DIV_STEPS].den)
    else $error("divider remainder not below denominator");

  // Root remainder of an unsaturated distance is at most twice the root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sv[SQ_STEPS] && !sq[SQ_STEPS].sat
    |-> sq[SQ_STEPS].rem <= (REMW'(sq[SQ_STEPS].root) << 1))
    else $error("square root remainder out of range");
`endif

endmodule

`default_nettype wire

>>> sim/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker
// Watches both stream channels of the segment closest-points block, computes
// the expected result of every accepted pair and compares it with the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_checker
  import scp_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [CW-1:0]     cfg_wdata,
  input  wire              s_tvalid,
  input  wire              s_tready,
  input  wire [IN_W-1:0]   s_tdata,
  input  wire              m_tvalid,
  input  wire              m_tready,
  input  wire [OUT_W-1:0]  m_tdata,
  output int               fail_count,
  output int               pending
);

  typedef logic signed [299:0] wide_t;

  typedef struct packed {
    logic [31:0] ps_x, ps_y, ps_z, qt_x, qt_y, qt_z;
    logic [16:0] param_s, param_t;
    logic [32:0] distance;
  } closest_t;

  logic [31:0] threshold;
  closest_t    closest_q[$];

  assign pending = closest_q.size();

  // Fraction of num over den in Q1.16, clamped to [0,1].
  function automatic logic [16:0] clamp_ratio(wide_t num, wide_t den);
    if (num <= 0) return 17'd0;
    if (num >= den) return 17'h10000;
    return 17'((num <<< 16) / den);
  endfunction

  function automatic wide_t dot(wide_t u[3], wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic closest_t closest_points(logic [IN_W-1:0] beat, logic [31:0] thr);
    wide_t p0[3], q0[3], p[3], q[3], r[3], ps[3], qt[3];
    wide_t a, b, c, d, e, det, sn, tn, be, sum, dk, cand;
    logic [16:0] s, t;
    logic [32:0] root;
    closest_t res;
    for (int k = 0; k < 3; k++) begin
      p0[k] = wide_t'($signed(beat[32*k +: 32]));
      q0[k] = wide_t'($signed(beat[32*(6+k) +: 32]));
      p[k]  = wide_t'($signed(beat[32*(3+k) +: 32])) - p0[k];
      q[k]  = wide_t'($signed(beat[32*(9+k) +: 32])) - q0[k];
      r[k]  = p0[k] - q0[k];
    end
    a = dot(p, p); b = dot(p, q); c = dot(q, q); d = dot(p, r); e = dot(q, r);
    det = a * c - b * b;
    if (det > (wide_t'(thr) <<< 48)) begin
      sn = b * e - c * d;
      tn = a * e - b * d;
      be = b + e;
      if (sn <= 0) begin
        if (e <= 0) begin s = clamp_ratio(-d, a); t = 0; end
        else if (e < c) begin s = 0; t = clamp_ratio(e, c); end
        else begin s = clamp_ratio(b - d, a); t = 17'h10000; end
      end else if (sn >= det) begin
        if (be <= 0) begin s = clamp_ratio(-d, a); t = 0; end
        else if (be < c) begin s = 17'h10000; t = clamp_ratio(be, c); end
        else begin s = clamp_ratio(b - d, a); t = 17'h10000; end
      end else if (tn <= 0) begin
        s = clamp_ratio(-d, a); t = 0;
      end else if (tn >= det) begin
        s = clamp_ratio(b - d, a); t = 17'h10000;
      end else begin
        s = clamp_ratio(sn, det); t = clamp_ratio(tn, det);
      end
    end else begin
      if (e <= 0) begin s = clamp_ratio(-d, a); t = 0; end
      else if (e >= c) begin s = clamp_ratio(b - d, a); t = 17'h10000; end
      else begin s = 0; t = clamp_ratio(e, c); end
    end
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      ps[k] = p0[k] + ((wide_t'(s) * p[k]) >>> 16);
      qt[k] = q0[k] + ((wide_t'(t) * q[k]) >>> 16);
      dk = qt[k] - ps[k];
      sum += dk * dk;
    end
    root = '0;
    if (sum >= (wide_t'(1) <<< 66)) root = '1;
    else begin
      for (int bit_i = 32; bit_i >= 0; bit_i--) begin
        cand = wide_t'({root[32:0]} | (33'd1 << bit_i));
        if (cand * cand <= sum) root[bit_i] = 1'b1;
      end
    end
    res.ps_x = ps[0][31:0]; res.ps_y = ps[1][31:0]; res.ps_z = ps[2][31:0];
    res.qt_x = qt[0][31:0]; res.qt_y = qt[1][31:0]; res.qt_z = qt[2][31:0];
    res.param_s = s; res.param_t = t; res.distance = root;
    return res;
  endfunction

  // Predict on input beats, compare on output beats.
  always @(posedge clk) begin
    closest_t got, want;
    if (rst) begin
      threshold <= 32'd1;
      closest_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (s_tvalid && s_tready)
        closest_q.insert(closest_q.size(), closest_points(s_tdata, threshold));
      if (m_tvalid && m_tready) begin
        got.ps_x = m_tdata[31:0];    got.ps_y = m_tdata[63:32];
        got.ps_z = m_tdata[95:64];   got.qt_x = m_tdata[127:96];
        got.qt_y = m_tdata[159:128]; got.qt_z = m_tdata[191:160];
        got.param_s = m_tdata[208:192]; got.param_t = m_tdata[225:209];
        got.distance = m_tdata[258:226];
        if (closest_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = closest_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_segment_closest_points_top.sv
// ----------------------------------------------------------------------------
// tb_segment_closest_points_top
// Drives directed and random segment pairs through the closest-points block
// under changing thresholds and backpressure; the checker scores the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_closest_points_top;
  import scp_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CW-1:0]     cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  int                fail_count, pending;
  int                send_idle = 26, recv_idle = 61;

  always #2 clk = ~clk;

  segment_closest_points_top DUT (.*);
  scp_checker u_checker (.*);

  // Receiver: random stalls at the current rate.
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  // Send one pair and wait for its beat to be taken; tvalid stays high after.
  task automatic send_pair(logic [IN_W-1:0] pair);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pair;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int span);
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return 32'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  // Pairs of several shapes: general, parallel, degenerate.
  function automatic logic [IN_W-1:0] rand_pair(int span);
    logic [IN_W-1:0] pair;
    logic [31:0] off;
    for (int k = 0; k < 12; k++) pair[32*k +: 32] = rand_coord(span);
    case ($urandom_range(4))
      0: for (int k = 0; k < 3; k++) pair[32*(3+k) +: 32] = pair[32*k +: 32];
      1: for (int k = 0; k < 3; k++) pair[32*(9+k) +: 32] = pair[32*(6+k) +: 32];
      2: begin
        off = $urandom_range(4096);
        for (int k = 0; k < 3; k++) begin
          pair[32*(6+k) +: 32] = pair[32*k +: 32] + off;
          pair[32*(9+k) +: 32] = pair[32*(3+k) +: 32] + off;
        end
      end
      default: ;
    endcase
    return pair;
  endfunction

  function automatic logic [IN_W-1:0] mk(int c[12]);
    logic [IN_W-1:0] pair;
    for (int k = 0; k < 12; k++) pair[32*k +: 32] = 32'(c[k] * 65536);
    return pair;
  endfunction

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] thr_set[5] = '{32'd0, 32'hffff_ffff, 32'd65536, 32'd1, 32'd300};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: skew, parallel, degenerate, endpoints, extremes.
    send_pair(mk('{0, 0, 0, 2, 0, 0, 1, -1, 1, 1, 1, 1}));
    send_pair(mk('{0, 0, 0, 1, 0, 0, 5, -1, 0, 5, 1, 0}));
    send_pair(mk('{0, 0, 0, 1, 0, 0, -5, -1, 0, -5, 1, 0}));
    send_pair(mk('{0, 0, 0, 4, 0, 0, 1, 1, 0, 3, 1, 0}));
    send_pair(mk('{0, 0, 0, 4, 0, 0, 6, 1, 0, 8, 1, 0}));
    send_pair(mk('{0, 0, 0, 4, 0, 0, -3, 1, 0, -1, 1, 0}));
    send_pair(mk('{1, 1, 1, 1, 1, 1, 0, 0, 0, 3, 3, 0}));
    send_pair(mk('{1, 2, 3, 1, 2, 3, 4, 5, 6, 4, 5, 6}));
    send_pair(mk('{0, 0, 0, 2, 2, 0, 0, 0, 5, 2, 2, 5}));
    send_pair(mk('{0, 0, 0, 1, 0, 0, 0, 3, -1, 0, 3, 1}));
    send_pair({6{32'h8000_0000, 32'h7fff_ffff}});
    send_pair({{3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}}});
    send_pair('1);
    send_pair('0);
    send_pair({12{32'h5555_aaaa}});

    // Random phases over several thresholds and idle mixes.
    for (int ph = 0; ph < 15; ph++) begin
      write_threshold(thr_set[ph % 5]);
      send_idle = (ph < 5) ? 26 : (ph < 10) ? 61 : 0;
      recv_idle = (ph < 5) ? 61 : (ph < 10) ? 26 : 0;
      for (int n = 0; n < 50; n++) begin
        if (ph == 7 && n == 25) begin
          s_tvalid <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
        send_pair(rand_pair((n % 4 == 0) ? 32'h7fff_ffff : 65536 * 64));
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
